>>> design/pcpt_pkg.sv
// Shared types and constants for the pulse-counted PWM timer.
package pcpt_pkg;

  // Channel count and field widths are fixed by the port layout
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned DIV_W    = 17;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_SET   = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE  = 2'd2;

  // One accepted command word as seen by the timebase and the channels
  typedef struct packed {
    logic                accept;
    kind_t               kind;
    logic [NUM_CH-1:0]   mask;
    logic [PULSE_W-1:0]  count;
  } cmd_t;

  // Timebase status toward the channels, valid in the cycle of the command
  typedef struct packed {
    logic compare_hit;  // counter step lands on the compare value
    logic at_or_above;  // new counter value is at or above the compare value
  } tb_evt_t;

endpackage

>>> design/pcpt_timebase.sv
// Shared prescaler and PWM up-counter with compare detection.
module pcpt_timebase #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pcpt_pkg::cmd_t                   cmd,
  input  logic [pcpt_pkg::DIV_W-1:0]       prescale_div,
  input  logic [pcpt_pkg::PERIOD_W-1:0]    period_len,
  input  logic [pcpt_pkg::CMP_W-1:0]       compare_value,
  output pcpt_pkg::tb_evt_t                evt
);

  localparam int unsigned CW = COUNTER_WIDTH;
  // Width wide enough for both the register fields and the full range 2^CW
  localparam int unsigned XW = (CW + 1 > pcpt_pkg::DIV_W) ? CW + 1 : pcpt_pkg::DIV_W;

  logic [CW-1:0] prescale_count_r, prescale_count_nxt;
  logic [CW-1:0] main_count_r, main_count_nxt;

  logic [XW-1:0] cnt_max_x;
  logic [XW-1:0] div_x, per_x;
  logic [CW:0]   div_eff, per_eff;
  logic [CW:0]   pre_inc;
  logic [CW-1:0] cmp_eff;
  logic          step;

  // Clamp divider and period into their usable ranges
  always_comb begin
    cnt_max_x = XW'(1) << CW;
    div_x     = XW'(prescale_div);
    per_x     = XW'(period_len);
    if (div_x == '0) begin
      div_x = XW'(1);
    end else if (div_x > cnt_max_x) begin
      div_x = cnt_max_x;
    end
    if (per_x < XW'(2)) begin
      per_x = XW'(2);
    end else if (per_x > cnt_max_x) begin
      per_x = cnt_max_x;
    end
    div_eff = div_x[CW:0];
    per_eff = per_x[CW:0];
    cmp_eff = CW'(compare_value);
  end

  // Advance prescaler and counter on a tick, clear both on start
  always_comb begin
    prescale_count_nxt = prescale_count_r;
    main_count_nxt     = main_count_r;
    pre_inc            = {1'b0, prescale_count_r} + (CW+1)'(1);
    step               = 1'b0;
    if (cmd.accept) begin
      case (cmd.kind)
        pcpt_pkg::KIND_TICK: begin
          if (pre_inc < div_eff) begin
            prescale_count_nxt = pre_inc[CW-1:0];
          end else begin
            prescale_count_nxt = '0;
            step               = 1'b1;
            if ({1'b0, main_count_r} >= per_eff - (CW+1)'(1)) begin
              main_count_nxt = '0;
            end else begin
              main_count_nxt = main_count_r + CW'(1);
            end
          end
        end
        pcpt_pkg::KIND_START: begin
          prescale_count_nxt = '0;
          main_count_nxt     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Report compare status of the new counter value
  always_comb begin
    evt.compare_hit = step && (main_count_nxt == cmp_eff);
    evt.at_or_above = (main_count_nxt >= cmp_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_count_r <= '0;
      main_count_r     <= '0;
    end else begin
      prescale_count_r <= prescale_count_nxt;
      main_count_r     <= main_count_nxt;
    end
  end

endmodule

>>> design/pcpt_channels.sv
// Per-channel run and limit flags, pulse counts and readback selection.
module pcpt_channels (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcpt_pkg::cmd_t                     cmd,
  input  pcpt_pkg::tb_evt_t                  evt,
  output logic [pcpt_pkg::NUM_CH-1:0]        pwm_nxt,
  output logic [pcpt_pkg::NUM_CH-1:0]        run_nxt,
  output logic [pcpt_pkg::NUM_CH-1:0]        limit_nxt,
  output logic [pcpt_pkg::PULSE_W-1:0]       readback_nxt
);

  localparam int unsigned NC = pcpt_pkg::NUM_CH;
  localparam int unsigned PW = pcpt_pkg::PULSE_W;

  logic [NC-1:0] run_r, limit_r;
  logic [PW-1:0] counts_r   [NC];
  logic [PW-1:0] counts_nxt [NC];

  // Update each channel from the command word and the compare event
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      run_nxt[i]    = run_r[i];
      limit_nxt[i]  = limit_r[i];
      counts_nxt[i] = counts_r[i];
      if (cmd.accept) begin
        case (cmd.kind)
          pcpt_pkg::KIND_TICK: begin
            if (evt.compare_hit && run_r[i] && limit_r[i]) begin
              if (counts_r[i] == '0) begin
                run_nxt[i]   = 1'b0;
                limit_nxt[i] = 1'b0;
              end else begin
                counts_nxt[i] = counts_r[i] - PW'(1);
              end
            end
          end
          pcpt_pkg::KIND_START: begin
            if (cmd.mask[i]) begin
              run_nxt[i] = 1'b1;
              if (counts_r[i] != '0) begin
                limit_nxt[i] = 1'b1;
              end
            end
          end
          pcpt_pkg::KIND_STOP: begin
            if (cmd.mask[i]) begin
              run_nxt[i]    = 1'b0;
              limit_nxt[i]  = 1'b0;
              counts_nxt[i] = '0;
            end
          end
          pcpt_pkg::KIND_SET: begin
            if (cmd.mask[i]) begin
              counts_nxt[i] = cmd.count;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Drive outputs high only while at or above compare
  assign pwm_nxt = evt.at_or_above ? run_nxt : '0;

  // Pick the updated count of the lowest selected channel
  always_comb begin
    readback_nxt = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (cmd.mask[i]) begin
        readback_nxt = counts_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      limit_r <= '0;
      for (int i = 0; i < NC; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      run_r   <= run_nxt;
      limit_r <= limit_nxt;
      for (int i = 0; i < NC; i++) begin
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

endmodule

>>> design/pulse_counted_pwm_timer_unit.sv
// Top level of the pulse-counted PWM timer: config registers and result register.
//
// Four-channel PWM timer driven by command words. A tick word advances the
// shared prescaler; on its terminal count the shared counter steps and wraps
// at period minus one. A running channel is high while the counter is at or
// above the compare value. Start words clear both counters and run the
// selected channels, stop words halt them and clear their pulse counts, and
// set words load pulse counts; a channel started with a nonzero count counts
// down on each compare hit and stops itself on the hit that finds it at zero.
// Every accepted word yields one result word holding the state after that word,
// from a single output register; a new word is taken every cycle while the output
// side keeps up, and also while a result waits if it is taken in that same cycle.
// The configuration port is always ready; write it only while the timer is idle.
module pulse_counted_pwm_timer_unit #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic [pcpt_pkg::NUM_CH-1:0]         in_channel_mask,
  input  logic [pcpt_pkg::PULSE_W-1:0]        in_count,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcpt_pkg::NUM_CH-1:0]         out_pwm_out,
  output logic [pcpt_pkg::NUM_CH-1:0]         out_running,
  output logic [pcpt_pkg::NUM_CH-1:0]         out_limited,
  output logic [pcpt_pkg::PULSE_W-1:0]        out_count_readback,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcpt_pkg::DIV_W-1:0]          cfg_data
);

  logic [pcpt_pkg::DIV_W-1:0]    prescale_div_r;
  logic [pcpt_pkg::PERIOD_W-1:0] period_len_r;
  logic [pcpt_pkg::CMP_W-1:0]    compare_value_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [pcpt_pkg::NUM_CH-1:0]   pwm_r, running_r, limited_r;
  logic [pcpt_pkg::PULSE_W-1:0]  readback_r;

  pcpt_pkg::cmd_t                cmd;
  pcpt_pkg::tb_evt_t             evt;
  logic [pcpt_pkg::NUM_CH-1:0]   pwm_nxt, run_nxt, limit_nxt;
  logic [pcpt_pkg::PULSE_W-1:0]  readback_nxt;

  // Take a word whenever the output register is free or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.accept = in_valid && in_ready;
    cmd.kind   = pcpt_pkg::kind_t'(in_kind);
    cmd.mask   = in_channel_mask;
    cmd.count  = in_count;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_div_r  <= pcpt_pkg::DIV_W'(1);
      period_len_r    <= pcpt_pkg::PERIOD_W'(65536);
      compare_value_r <= pcpt_pkg::CMP_W'(32768);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcpt_pkg::REG_PRESCALE: prescale_div_r  <= cfg_data;
        pcpt_pkg::REG_PERIOD:   period_len_r    <= pcpt_pkg::PERIOD_W'(cfg_data);
        pcpt_pkg::REG_COMPARE:  compare_value_r <= cfg_data[pcpt_pkg::CMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcpt_timebase #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_timebase (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .prescale_div  (prescale_div_r),
    .period_len    (period_len_r),
    .compare_value (compare_value_r),
    .evt           (evt)
  );

  pcpt_channels u_channels (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .evt          (evt),
    .pwm_nxt      (pwm_nxt),
    .run_nxt      (run_nxt),
    .limit_nxt    (limit_nxt),
    .readback_nxt (readback_nxt)
  );

  // Hold the result word until taken
  assign out_valid_nxt = cmd.accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pwm_r      <= pwm_nxt;
      running_r  <= run_nxt;
      limited_r  <= limit_nxt;
      readback_r <= readback_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pwm_out        = pwm_r;
  assign out_running        = running_r;
  assign out_limited        = limited_r;
  assign out_count_readback = readback_r;

endmodule

>>> tb/pwm_timer_shadow_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that tracks the timer state and checks each result word.
package pwm_timer_shadow_pkg;
  import pcpt_pkg::*;

  typedef struct {
    logic [NUM_CH-1:0]  pwm;
    logic [NUM_CH-1:0]  run;
    logic [NUM_CH-1:0]  lim;
    logic [PULSE_W-1:0] readback;
  } timer_status_t;

  class pwm_timer_shadow;
    logic [DIV_W-1:0]    div_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [CMP_W-1:0]    cmp_reg;
    logic [15:0]         prescale_ctr;
    logic [15:0]         main_ctr;
    logic [NUM_CH-1:0]   run_flags;
    logic [NUM_CH-1:0]   limit_flags;
    logic [PULSE_W-1:0]  pulses [NUM_CH];
    timer_status_t       expected_status [$];
    int unsigned         mismatches;
    int unsigned         words_checked;
    int unsigned         self_stops;

    function new();
      div_reg      = 17'd1;
      period_reg   = 17'h10000;
      cmp_reg      = 16'h8000;
      prescale_ctr = '0;
      main_ctr     = '0;
      run_flags    = '0;
      limit_flags  = '0;
      foreach (pulses[i]) pulses[i] = '0;
      mismatches    = 0;
      words_checked = 0;
      self_stops    = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] data);
      case (idx)
        REG_PRESCALE: div_reg = data;
        REG_PERIOD:   period_reg = data;
        REG_COMPARE:  cmp_reg = data[CMP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Advance the prescaler, step the counter on terminal count, apply compare events
    function void advance_timebase();
      int unsigned div_eff;
      int unsigned per_eff;
      div_eff = div_reg;
      per_eff = period_reg;
      if (div_eff < 1) div_eff = 1;
      if (div_eff > 32'h10000) div_eff = 32'h10000;
      if (per_eff < 2) per_eff = 2;
      if (per_eff > 32'h10000) per_eff = 32'h10000;
      if (prescale_ctr + 32'd1 < div_eff) begin
        prescale_ctr++;
        return;
      end
      prescale_ctr = '0;
      if (main_ctr >= per_eff - 1) main_ctr = '0;
      else main_ctr++;
      if (main_ctr != cmp_reg) return;
      // Count down limited channels; a channel found at zero drops out
      for (int i = 0; i < NUM_CH; i++) begin
        if (run_flags[i] && limit_flags[i]) begin
          if (pulses[i] == '0) begin
            run_flags[i]   = 1'b0;
            limit_flags[i] = 1'b0;
            self_stops++;
          end else begin
            pulses[i]--;
          end
        end
      end
    endfunction

    // Note one accepted command word and queue the status it must produce
    function void take_word(kind_t kind, logic [NUM_CH-1:0] mask,
                            logic [PULSE_W-1:0] count);
      timer_status_t st;
      case (kind)
        KIND_TICK: advance_timebase();
        KIND_START: begin
          prescale_ctr = '0;
          main_ctr     = '0;
          for (int i = 0; i < NUM_CH; i++) begin
            if (mask[i]) begin
              run_flags[i] = 1'b1;
              if (pulses[i] != '0) limit_flags[i] = 1'b1;
            end
          end
        end
        KIND_STOP: begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (mask[i]) begin
              run_flags[i]   = 1'b0;
              limit_flags[i] = 1'b0;
              pulses[i]      = '0;
            end
          end
        end
        KIND_SET: begin
          for (int i = 0; i < NUM_CH; i++)
            if (mask[i]) pulses[i] = count;
        end
        default: ;
      endcase
      st.pwm      = (main_ctr >= cmp_reg) ? run_flags : '0;
      st.run      = run_flags;
      st.lim      = limit_flags;
      st.readback = '0;
      // Lowest selected channel wins, so walk down from the top
      for (int i = NUM_CH - 1; i >= 0; i--)
        if (mask[i]) st.readback = pulses[i];
      expected_status.push_back(st);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at result word %0d: %s", words_checked, msg);
    endtask

    // Compare one result word against the oldest queued status
    task check_word(input logic [NUM_CH-1:0] pwm, input logic [NUM_CH-1:0] run,
                    input logic [NUM_CH-1:0] lim, input logic [PULSE_W-1:0] rb);
      timer_status_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("unexpected word pwm=%h run=%h lim=%h rb=%h", pwm, run, lim, rb));
        return;
      end
      want = expected_status.pop_front();
      words_checked++;
      if (pwm !== want.pwm)
        report($sformatf("pwm_out expected %h got %h", want.pwm, pwm));
      if (run !== want.run)
        report($sformatf("running expected %h got %h", want.run, run));
      if (lim !== want.lim)
        report($sformatf("limited expected %h got %h", want.lim, lim));
      if (rb !== want.readback)
        report($sformatf("count_readback expected %h got %h", want.readback, rb));
    endtask
  endclass

endpackage

>>> tb/tb_pulse_counted_pwm_timer_unit.sv
`timescale 1ns / 100ps
// Top-level testbench for the pulse-counted PWM timer unit.
module tb_pulse_counted_pwm_timer_unit;
  import pcpt_pkg::*;
  import pwm_timer_shadow_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int STALL_LIMIT     = 1000;
  localparam int WORDS_PER_PHASE = 160;
  localparam int NUM_PHASES      = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_kind;
  logic [NUM_CH-1:0]    in_channel_mask;
  logic [PULSE_W-1:0]   in_count;
  logic                 out_valid;
  logic                 out_ready;
  logic [NUM_CH-1:0]    out_pwm_out;
  logic [NUM_CH-1:0]    out_running;
  logic [NUM_CH-1:0]    out_limited;
  logic [PULSE_W-1:0]   out_count_readback;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIV_W-1:0]     cfg_data;

  pwm_timer_shadow shadow;
  bit              steady;
  int              ready_hold;
  int              words_sent;
  int              phases_run;

  // Timer settings per random phase: prescaler, period, compare
  logic [DIV_W-1:0] phase_div [NUM_PHASES] = '{
    17'd2, 17'd0, 17'd3, 17'd1, 17'd2, 17'd1, 17'h10000, 17'h1FFFF, 17'd5, 17'd1, 17'd1};
  logic [DIV_W-1:0] phase_per [NUM_PHASES] = '{
    17'd6, 17'd1, 17'd7, 17'd0, 17'd10, 17'h1FFFF, 17'd2, 17'h10000, 17'd3, 17'd2, 17'd5};
  logic [DIV_W-1:0] phase_cmp [NUM_PHASES] = '{
    17'd4, 17'h10001, 17'd0, 17'd0, 17'd15, 17'd3, 17'd1, 17'hFFFF, 17'd2, 17'd1, 17'd0};

  pulse_counted_pwm_timer_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_channel_mask    (in_channel_mask),
    .in_count           (in_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pwm_out        (out_pwm_out),
    .out_running        (out_running),
    .out_limited        (out_limited),
    .out_count_readback (out_count_readback),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    return pick_len();
  endfunction

  function automatic logic [PULSE_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return PULSE_W'($urandom_range(1, 4));
    return PULSE_W'($urandom);
  endfunction

  // Drain result words, stall at random, hold ready high during steady stretches
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      shadow.check_word(out_pwm_out, out_running, out_limited, out_count_readback);
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_len() - 1;
    end
  end

  // Abort when no channel moves a word for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one command word, hold it until taken, then idle at random
  task automatic send_word(kind_t kind, logic [NUM_CH-1:0] mask, logic [PULSE_W-1:0] count);
    int gap;
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_channel_mask <= mask;
    in_count        <= count;
    do @(posedge clk); while (!in_ready);
    shadow.take_word(kind, mask, count);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every queued status to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow.load_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [DIV_W-1:0] div, logic [DIV_W-1:0] per,
                              logic [DIV_W-1:0] cmp, bit touch_spare);
    drain_results();
    write_cfg(REG_PRESCALE, div);
    write_cfg(REG_PERIOD, per);
    write_cfg(REG_COMPARE, cmp);
    if (touch_spare) write_cfg(REG_SPARE, DIV_W'($urandom));
    phases_run++;
  endtask

  // Load counts, start, then clock ticks with occasional mid-run commands
  task automatic pulse_train();
    logic [NUM_CH-1:0] sel;
    int                r;
    sel = NUM_CH'($urandom_range(1, 15));
    for (int i = 0; i < NUM_CH; i++)
      if (sel[i]) send_word(KIND_SET, NUM_CH'(1 << i), pick_count());
    if ($urandom_range(0, 3) == 0) sel = sel | NUM_CH'($urandom);
    send_word(KIND_START, sel, PULSE_W'($urandom));
    repeat ($urandom_range(4, 48)) begin
      r = $urandom_range(0, 99);
      if (r < 85)
        send_word(KIND_TICK, NUM_CH'($urandom), PULSE_W'($urandom));
      else if (r < 92)
        send_word(KIND_SET, NUM_CH'(1 << $urandom_range(0, NUM_CH - 1)), pick_count());
      else if (r < 96)
        send_word(KIND_STOP, NUM_CH'($urandom), PULSE_W'($urandom));
      else
        send_word(KIND_START, NUM_CH'($urandom), PULSE_W'($urandom));
    end
  endtask

  task automatic run_random_phase(int budget);
    int stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 70) begin
        pulse_train();
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(kind_t'($urandom_range(0, 3)), NUM_CH'($urandom), PULSE_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Hand-picked words: full counts, readback, limit handling and final pulses
  task automatic run_directed();
    send_word(KIND_TICK, 4'h0, 16'h0000);
    send_word(KIND_SET, 4'hF, 16'hFFFF);
    load_setting(17'd1, 17'd4, 17'd2, 1'b0);
    send_word(KIND_TICK, 4'h2, 16'h0000);
    send_word(KIND_SET, 4'h4, 16'h0001);
    send_word(KIND_SET, 4'h8, 16'h0000);
    send_word(KIND_SET, 4'h1, 16'h0002);
    send_word(KIND_START, 4'hF, 16'h0000);
    // replace a count on a running limited channel; its limit flag stays
    send_word(KIND_SET, 4'h2, 16'h0000);
    for (int i = 0; i < 14; i++)
      send_word(KIND_TICK, NUM_CH'(1 << (i % NUM_CH)), 16'h0000);
    send_word(KIND_STOP, 4'hF, 16'hFFFF);
    send_word(KIND_START, 4'h6, 16'h0000);
    send_word(KIND_STOP, 4'h0, 16'h5A5A);
  endtask

  initial begin
    shadow          = new();
    steady          = 1'b0;
    ready_hold      = 0;
    words_sent      = 0;
    phases_run      = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_TICK;
    in_channel_mask <= '0;
    in_count        <= '0;
    out_ready       <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_PRESCALE;
    cfg_data        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_setting(phase_div[p], phase_per[p], phase_cmp[p], p[0]);
      run_random_phase(WORDS_PER_PHASE);
    end
    drain_results();

    $display("Sent %0d command words over %0d timer settings; %0d result words checked.",
             words_sent, phases_run, shadow.words_checked);
    $display("Channels stopped on their final pulse %0d times; %0d mismatches.",
             shadow.self_stops, shadow.mismatches);
    if (shadow.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
